// File: rtl/core/trqs_pkg.sv
// Shared types and constants for the thread ready queue scheduler.
// Used by the channel interfaces, the ready ring and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trqs_pkg;

  localparam int MAX_THREADS = 64;
  localparam int TID_W       = 6;
  localparam int CMD_W       = 3;
  localparam int TGT_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int PTR_W       = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;

  typedef logic [TID_W-1:0] tid_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_EXIT     = 3'd1,
    CMD_KILL     = 3'd2,
    CMD_YIELD    = 3'd3,
    CMD_YIELD_TO = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TID_INVALID = 3'd1,
    ST_THREAD_BAD  = 3'd2,
    ST_NO_THREAD   = 3'd3,
    ST_LAST_EXIT   = 3'd4
  } status_t;

  // Operations on the ready ring
  typedef enum logic [2:0] {
    RING_NOP,
    RING_PUSH,
    RING_POP,
    RING_ROTATE,
    RING_REMOVE
  } ring_op_t;

  typedef struct packed {
    ring_op_t op;
    tid_t     tid;       // pushed id, or id to remove
    tid_t     fill_tid;  // id written into the freed tail slot on remove
    logic     refill;    // remove: refill the tail slot instead of shrinking
  } ring_req_t;

  typedef struct packed {
    logic empty;
    logic done;      // remove walk finished (one-cycle pulse)
    logic found;     // remove hit, valid with done
    tid_t head_tid;  // read data, valid the cycle after a pop or rotate
  } ring_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/trqs_if.sv
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on trqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface trqs_cmd_if import trqs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [TGT_W-1:0] target_tid;

  modport source (output valid, output command, output target_tid, input ready);
  modport sink (input valid, input command, input target_tid, output ready);
endinterface

interface trqs_rsp_if import trqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  tid_t                result_tid;
  tid_t                running_tid;

  modport source (output valid, output status, output result_tid, output running_tid,
                  input ready);
  modport sink (input valid, input status, input result_tid, input running_tid,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/trqs_ring.sv
// Ready ring: circular FIFO of thread ids in a one-port-read synchronous memory,
// with push, pop, rotate and an ordered remove that closes the gap.
// Depends on trqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trqs_ring import trqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ring_req_t req,
  output ring_rsp_t rsp
);

  tid_t mem [MAX_THREADS];
  tid_t rd_data_r;

  ptr_t head_r, head_nxt;
  ptr_t tail_r, tail_nxt;
  logic scan_r, scan_nxt;
  logic pend_r, pend_nxt;
  logic found_r, found_nxt;
  logic done_r, done_nxt;
  ptr_t issue_r, issue_nxt;
  ptr_t pend_addr_r, pend_addr_nxt;
  tid_t tgt_r, tgt_nxt;
  tid_t fill_r, fill_nxt;
  logic refill_r, refill_nxt;

  logic rd_en;
  ptr_t rd_addr;
  logic wr_en;
  ptr_t wr_addr;
  tid_t wr_data;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(MAX_THREADS - 1) : p - 1'b1;
  endfunction

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    done_nxt      = 1'b0;
    issue_nxt     = issue_r;
    pend_addr_nxt = pend_addr_r;
    tgt_nxt       = tgt_r;
    fill_nxt      = fill_r;
    refill_nxt    = refill_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = req.tid;

    if (scan_r) begin
      // Check the returned slot; after a hit, move each later entry forward
      if (pend_r) begin
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = ptr_dec(pend_addr_r);
          wr_data = rd_data_r;
        end
        if (rd_data_r == tgt_r) begin
          found_nxt = 1'b1;
        end
      end
      if (issue_r != tail_r) begin
        rd_en         = 1'b1;
        rd_addr       = issue_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = issue_r;
        issue_nxt     = ptr_inc(issue_r);
      end else begin
        pend_nxt = 1'b0;
        if (!pend_r) begin
          scan_nxt = 1'b0;
          done_nxt = 1'b1;
          if (found_r) begin
            if (refill_r) begin
              wr_en   = 1'b1;
              wr_addr = ptr_dec(tail_r);
              wr_data = fill_r;
            end else begin
              tail_nxt = ptr_dec(tail_r);
            end
          end
        end
      end
    end else begin
      case (req.op)
        RING_PUSH: begin
          wr_en    = 1'b1;
          tail_nxt = ptr_inc(tail_r);
        end
        RING_POP: begin
          rd_en    = 1'b1;
          head_nxt = ptr_inc(head_r);
        end
        RING_ROTATE: begin
          rd_en    = 1'b1;
          wr_en    = 1'b1;
          head_nxt = ptr_inc(head_r);
          tail_nxt = ptr_inc(tail_r);
        end
        RING_REMOVE: begin
          scan_nxt   = 1'b1;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          issue_nxt  = head_r;
          tgt_nxt    = req.tid;
          fill_nxt   = req.fill_tid;
          refill_nxt = req.refill;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      scan_r  <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      done_r  <= done_nxt;
    end
    issue_r     <= issue_nxt;
    pend_addr_r <= pend_addr_nxt;
    tgt_r       <= tgt_nxt;
    fill_r      <= fill_nxt;
    refill_r    <= refill_nxt;
  end

  assign rsp.empty    = (head_r == tail_r);
  assign rsp.done     = done_r;
  assign rsp.found    = found_r;
  assign rsp.head_tid = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/thread_ready_queue_scheduler_top.sv
// Thread scheduler top level: request decode, live map, running id and result register.
// Depends on trqs_pkg, trqs_cmd_if / trqs_rsp_if and trqs_ring.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   command[2:0], target_tid[7:0] signed
//   out_chan  out  valid/ready   status[2:0], result_tid[5:0], running_tid[5:0]
//
// One request is handled at a time. create, a request rejected at decode, a yield_to of
// the running id, an exit or yield with an empty queue and an unknown command go from
// decode straight to the result state; exit and yield with a queued thread pass a pop
// state first (one ring memory read for the head). A kill or yield_to past the checks
// walks the ring from head to tail in a scan state, one memory read per cycle.
// The result register frees the input side: a new request
// is taken while the last result still waits on out_chan.ready.
// Reset (rst_n low at a rising edge) leaves thread 0 running and live, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module thread_ready_queue_scheduler_top import trqs_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  trqs_cmd_if.sink   in_chan,
  trqs_rsp_if.source out_chan
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic found;
    tid_t tid;
  } free_id_t;

  state_t                  state_r, state_nxt;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic signed [TGT_W-1:0] tgt_r, tgt_nxt;
  tid_t                    cur_r, cur_nxt;
  logic [MAX_THREADS-1:0]  live_r, live_nxt;
  status_t                 status_r, status_nxt;
  tid_t                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  tid_t                    out_res_r, out_res_nxt;
  tid_t                    out_run_r, out_run_nxt;

  ring_req_t ring_req;
  ring_rsp_t ring_rsp;

  free_id_t free_id;
  logic     tgt_in_range;
  logic     tgt_is_cur;
  tid_t     tgt_tid;

  // Lowest id with a clear live bit
  function automatic free_id_t find_free(input logic [MAX_THREADS-1:0] live);
    free_id_t r;
    r.found = 1'b0;
    r.tid   = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        r.found = 1'b1;
        r.tid   = TID_W'(i);
      end
    end
    return r;
  endfunction

  trqs_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .rsp   (ring_rsp)
  );

  assign free_id      = find_free(live_r);
  assign tgt_in_range = !tgt_r[TGT_W-1] && ($unsigned(tgt_r) < TGT_W'(MAX_THREADS));
  assign tgt_is_cur   = ($unsigned(tgt_r) == TGT_W'(cur_r));
  assign tgt_tid      = tgt_r[TID_W-1:0];

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tgt_nxt        = tgt_r;
    cur_nxt        = cur_r;
    live_nxt       = live_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_res_nxt    = out_res_r;
    out_run_nxt    = out_run_r;
    ring_req       = '{op: RING_NOP, tid: cur_r, fill_tid: cur_r, refill: 1'b0};

    // Drop the result once the sink takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt   = in_chan.command;
          tgt_nxt   = in_chan.target_tid;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_OK;
        res_nxt    = cur_r;
        state_nxt  = S_RESP;
        case (cmd_r)
          CMD_CREATE: begin
            if (!free_id.found) begin
              status_nxt = ST_NO_THREAD;
            end else begin
              live_nxt[free_id.tid[PTR_W-1:0]] = 1'b1;
              ring_req.op  = RING_PUSH;
              ring_req.tid = free_id.tid;
              res_nxt      = free_id.tid;
            end
          end
          CMD_EXIT: begin
            if (ring_rsp.empty) begin
              status_nxt = ST_LAST_EXIT;
            end else begin
              ring_req.op = RING_POP;
              state_nxt   = S_POP;
            end
          end
          CMD_KILL: begin
            if (tgt_is_cur) begin
              status_nxt = ST_THREAD_BAD;
            end else if (!tgt_in_range) begin
              status_nxt = ST_TID_INVALID;
            end else if (!live_r[tgt_tid[PTR_W-1:0]]) begin
              status_nxt = ST_NO_THREAD;
            end else begin
              ring_req.op  = RING_REMOVE;
              ring_req.tid = tgt_tid;
              state_nxt    = S_SCAN;
            end
          end
          CMD_YIELD: begin
            // Requeue the running id and take the head in one ring access
            if (!ring_rsp.empty) begin
              ring_req.op  = RING_ROTATE;
              ring_req.tid = cur_r;
              state_nxt    = S_POP;
            end
          end
          CMD_YIELD_TO: begin
            if (tgt_is_cur) begin
              status_nxt = ST_OK;
            end else if (!tgt_in_range) begin
              status_nxt = ST_TID_INVALID;
            end else begin
              // On a hit the ring puts the running id in the freed tail slot
              ring_req.op       = RING_REMOVE;
              ring_req.tid      = tgt_tid;
              ring_req.fill_tid = cur_r;
              ring_req.refill   = 1'b1;
              state_nxt         = S_SCAN;
            end
          end
          default: ;
        endcase
      end

      S_POP: begin
        // Head id is back from the ring memory
        if (cmd_r == CMD_EXIT) begin
          live_nxt[cur_r[PTR_W-1:0]] = 1'b0;
        end
        cur_nxt   = ring_rsp.head_tid;
        res_nxt   = ring_rsp.head_tid;
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        // Hold until the ring finishes its walk
        if (ring_rsp.done) begin
          state_nxt = S_RESP;
          if (ring_rsp.found) begin
            res_nxt = tgt_tid;
            if (cmd_r == CMD_KILL) begin
              live_nxt[tgt_tid[PTR_W-1:0]] = 1'b0;
            end else begin
              cur_nxt = tgt_tid;
            end
          end else if (cmd_r == CMD_KILL) begin
            status_nxt = ST_NO_THREAD;
          end else begin
            status_nxt = ST_THREAD_BAD;
          end
        end
      end

      S_RESP: begin
        // Load the result register as soon as it is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_res_nxt    = res_r;
          out_run_nxt    = cur_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      live_r      <= MAX_THREADS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_res_r    <= out_res_nxt;
    out_run_r    <= out_run_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.result_tid  = out_res_r;
  assign out_chan.running_tid = out_run_r;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the thread ready queue scheduler: directed table, then random
// requests checked against an in-bench scheduler predictor. Needs trqs_pkg, the
// trqs_cmd_if / trqs_rsp_if channels and thread_ready_queue_scheduler_top.
`timescale 1ns / 1ps

module testbench;
  import trqs_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PCT       = 17;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 80;   // a kill walk over a full queue, with margin
  localparam int TOTAL_REQUESTS = 1450;
  localparam int MAX_REPORTS    = 50;

  // Command codes the block has no meaning for; it must answer them as no-ops.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_YIELD_TO + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = CMD_W'((1 << CMD_W) - 1);

  // Extremes of the signed target field.
  localparam logic [TGT_W-1:0] TGT_MOST_NEG = TGT_W'(1 << (TGT_W - 1));
  localparam logic [TGT_W-1:0] TGT_MOST_POS = TGT_W'((1 << (TGT_W - 1)) - 1);
  localparam logic [TGT_W-1:0] TGT_MINUS_ONE = '1;

  typedef struct packed {
    status_t status;
    tid_t    result_tid;
    tid_t    running_tid;
  } sched_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [TGT_W-1:0] tgt;
    bit               typed;   // expected result written into the row
    sched_result_t    want;
  } table_row_t;

  logic clk;
  logic rst_n;

  trqs_cmd_if in_chan ();
  trqs_rsp_if out_chan ();

  thread_ready_queue_scheduler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Scheduler model: running id, live bitmap and the ready ring with its pointers.
  tid_t                   run_tid;
  logic [MAX_THREADS-1:0] live_ids;
  tid_t                   ready_ring [MAX_THREADS];
  ptr_t                   ring_head;
  ptr_t                   ring_tail;
  int                     deepest_queue;

  sched_result_t pending_results [$];
  table_row_t    request_table [$];

  int  idle_pct;
  bit  hold_request;
  int  requests_sent;
  int  results_seen;
  int  mismatches;
  int  quiet_cycles;
  int  status_hits [5];

  // Clock and reset.
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ready ring model
  // ---------------------------------------------------------------------------
  function automatic ptr_t ring_next(ptr_t p);
    return ptr_t'((int'(p) + 1) % MAX_THREADS);
  endfunction

  function automatic int queue_depth();
    return (int'(ring_tail) - int'(ring_head) + MAX_THREADS) % MAX_THREADS;
  endfunction

  function automatic void ring_push(tid_t id);
    ready_ring[ring_tail] = id;
    ring_tail = ring_next(ring_tail);
  endfunction

  function automatic tid_t ring_pop();
    tid_t id;
    id = ready_ring[ring_head];
    ring_head = ring_next(ring_head);
    return id;
  endfunction

  // Pull an id out of the queue and close the gap behind it.
  function automatic bit ring_remove(tid_t id);
    ptr_t p;
    ptr_t n;
    bit   found;
    found = 1'b0;
    p = ring_head;
    for (int g = 0; g < MAX_THREADS && p != ring_tail; g++) begin
      n = ring_next(p);
      if (ready_ring[p] == id) found = 1'b1;
      if (found && n != ring_tail) ready_ring[p] = ready_ring[n];
      p = n;
    end
    if (found) ring_tail = ptr_t'((int'(ring_tail) + MAX_THREADS - 1) % MAX_THREADS);
    return found;
  endfunction

  function automatic int lowest_free_id();
    for (int i = 0; i < MAX_THREADS; i++)
      if (!live_ids[i]) return i;
    return -1;
  endfunction

  // Advance the model by one request and return the result it must produce.
  function automatic sched_result_t predict_step(logic [CMD_W-1:0] cmd,
                                                 logic signed [TGT_W-1:0] tgt);
    sched_result_t r;
    int            t;
    int            id;
    r.status     = ST_OK;
    r.result_tid = run_tid;
    t = int'(tgt);
    case (cmd)
      CMD_CREATE: begin
        id = lowest_free_id();
        if (id < 0) begin
          r.status = ST_NO_THREAD;
        end else begin
          live_ids[id] = 1'b1;
          ring_push(tid_t'(id));
          r.result_tid = tid_t'(id);
        end
      end
      CMD_EXIT: begin
        if (ring_head == ring_tail) begin
          r.status = ST_LAST_EXIT;
        end else begin
          id = ring_pop();
          live_ids[run_tid] = 1'b0;
          run_tid = tid_t'(id);
          r.result_tid = run_tid;
        end
      end
      CMD_KILL: begin
        if (t == int'(run_tid)) r.status = ST_THREAD_BAD;
        else if (t < 0 || t >= MAX_THREADS) r.status = ST_TID_INVALID;
        else if (!live_ids[t]) r.status = ST_NO_THREAD;
        else if (!ring_remove(tid_t'(t))) r.status = ST_NO_THREAD;
        else begin
          live_ids[t] = 1'b0;
          r.result_tid = tid_t'(t);
        end
      end
      CMD_YIELD: begin
        if (ring_head != ring_tail) begin
          id = ring_pop();
          ring_push(run_tid);
          run_tid = tid_t'(id);
          r.result_tid = run_tid;
        end
      end
      CMD_YIELD_TO: begin
        if (t == int'(run_tid)) r.result_tid = run_tid;
        else if (t < 0 || t >= MAX_THREADS) r.status = ST_TID_INVALID;
        else if (!ring_remove(tid_t'(t))) r.status = ST_THREAD_BAD;
        else begin
          ring_push(run_tid);
          run_tid = tid_t'(t);
          r.result_tid = run_tid;
        end
      end
      default: ;
    endcase
    r.running_tid = run_tid;
    if (queue_depth() > deepest_queue) deepest_queue = queue_depth();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly aim at ids that are queued, so kill and yield_to walk the ring and hit.
  function automatic logic [TGT_W-1:0] pick_target();
    int k;
    int d;
    k = $urandom_range(99);
    d = queue_depth();
    if (k < 60 && d > 0)
      return TGT_W'(ready_ring[ptr_t'((int'(ring_head) + $urandom_range(d - 1)) % MAX_THREADS)]);
    if (k < 72) return TGT_W'(run_tid);
    if (k < 88) return TGT_W'($urandom_range(MAX_THREADS - 1));
    return TGT_W'($urandom_range(255));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int create_w);
    int k;
    if ($urandom_range(99) < create_w) return CMD_CREATE;
    k = $urandom_range(99);
    if (k < 20) return CMD_EXIT;
    if (k < 45) return CMD_KILL;
    if (k < 65) return CMD_YIELD;
    if (k < 94) return CMD_YIELD_TO;
    return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [TGT_W-1:0] tgt, bit typed,
                                  status_t st, int res, int run);
    table_row_t row;
    row.cmd  = cmd;
    row.tgt  = tgt;
    row.typed = typed;
    row.want.status      = st;
    row.want.result_tid  = tid_t'(res);
    row.want.running_tid = tid_t'(run);
    request_table.push_back(row);
  endfunction

  // Drive one request from the falling edge, hold it until a rising edge sees ready,
  // then record what the block owes for it.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TGT_W-1:0] tgt,
                              input bit typed, input sched_result_t typed_result);
    sched_result_t predicted;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_chan.valid      = 1'b1;
    in_chan.command    = cmd;
    in_chan.target_tid = tgt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = predict_step(cmd, tgt);
    pending_results.push_back(typed ? typed_result : predicted);
    requests_sent++;
  endtask

  task automatic send_mixed(input int create_w);
    send_request(pick_command(create_w), pick_target(), 1'b0, '0);
  endtask

  // Drop valid and hold the sender until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS)
      $display("%0t mismatch at result %0d: %s got %0d want %0d",
               $time, results_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request   = 1'b0;
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_chan.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each returned result with the oldest one owed.
  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.status <= ST_LAST_EXIT) status_hits[out_chan.status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending, status", int'(out_chan.status), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", int'(out_chan.status), int'(want.status));
        if (out_chan.result_tid !== want.result_tid)
          report_mismatch("result_tid", int'(out_chan.result_tid), int'(want.result_tid));
        if (out_chan.running_tid !== want.running_tid)
          report_mismatch("running_tid", int'(out_chan.running_tid), int'(want.running_tid));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results still owed",
                 quiet_cycles, pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_CREATE;
    in_chan.target_tid = '0;
    idle_pct           = IDLE_PCT;
    hold_request       = 1'b0;
    requests_sent      = 0;
    results_seen       = 0;
    mismatches         = 0;
    quiet_cycles       = 0;
    deepest_queue      = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Model state after reset: thread 0 runs and is live, queue empty.
    run_tid   = '0;
    live_ids  = MAX_THREADS'(1);
    ring_head = '0;
    ring_tail = '0;
    foreach (ready_ring[i]) ready_ring[i] = '0;

    // Directed table. Rows right after reset and most error cases carry their answer;
    // the rows that switch threads and the later rows are left to the predictor.
    add_row(CMD_EXIT,      '0,            1, ST_LAST_EXIT,   0, 0); // exit, queue empty
    add_row(CMD_YIELD,     '0,            1, ST_OK,          0, 0); // yield, queue empty
    add_row(CMD_KILL,      '0,            1, ST_THREAD_BAD,  0, 0); // kill the running id
    add_row(CMD_KILL,      TGT_MOST_NEG,  1, ST_TID_INVALID, 0, 0);
    add_row(CMD_KILL,      TGT_MOST_POS,  1, ST_TID_INVALID, 0, 0);
    add_row(CMD_YIELD_TO,  TGT_W'(MAX_THREADS), 1, ST_TID_INVALID, 0, 0);
    add_row(CMD_YIELD_TO,  '0,            1, ST_OK,          0, 0); // to itself: no switch
    add_row(CMD_YIELD_TO,  TGT_W'(5),     1, ST_THREAD_BAD,  0, 0); // target not queued
    add_row(CMD_KILL,      TGT_W'(5),     1, ST_NO_THREAD,   0, 0); // target not live
    add_row(CMD_YIELD_TO,  TGT_MOST_NEG,  1, ST_TID_INVALID, 0, 0);
    add_row(CMD_CREATE,    TGT_MINUS_ONE, 1, ST_OK,          1, 0);
    add_row(CMD_CREATE,    '0,            1, ST_OK,          2, 0);
    add_row(CMD_CREATE,    '0,            1, ST_OK,          3, 0);
    add_row(CMD_YIELD,     '0,            0, ST_OK,          0, 0);
    add_row(CMD_YIELD_TO,  TGT_W'(3),     0, ST_OK,          0, 0); // pull from mid-queue
    add_row(CMD_KILL,      '0,            0, ST_OK,          0, 0); // kill a queued thread
    add_row(CMD_KILL,      TGT_MINUS_ONE, 0, ST_OK,          0, 0);
    add_row(CMD_KILL,      TGT_W'(1),     0, ST_OK,          0, 0); // kill the queue tail
    add_row(CMD_UNUSED_LO, TGT_MOST_POS,  0, ST_OK,          0, 0);
    add_row(CMD_UNUSED_HI, TGT_MINUS_ONE, 0, ST_OK,          0, 0);
    add_row(CMD_EXIT,      '0,            0, ST_OK,          0, 0);
    add_row(CMD_CREATE,    '0,            0, ST_OK,          0, 0); // reuse a freed id
    add_row(CMD_EXIT,      '0,            0, ST_OK,          0, 0);
    add_row(CMD_EXIT,      '0,            0, ST_OK,          0, 0);
    add_row(CMD_EXIT,      '0,            0, ST_OK,          0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (request_table[i])
      send_request(request_table[i].cmd, request_table[i].tgt,
                   request_table[i].typed, request_table[i].want);
    wait_drained();

    // Random mix with idling on both sides.
    repeat (400) send_mixed(30);
    wait_drained();

    // Stretch with no idling: fill every id, run creates into the full pool,
    // then work the deep queue with kills and yield_tos.
    idle_pct = 0;
    repeat (MAX_THREADS + 2) send_request(CMD_CREATE, TGT_W'($urandom_range(255)), 1'b0, '0);
    repeat (200) send_mixed(10);
    wait_drained();

    // Long receiver hold-off while requests keep coming, so the block backs up.
    idle_pct = IDLE_PCT;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (40) send_mixed(25);
    wait_drained();

    // Exit every queued thread, then once more with the queue empty.
    while (queue_depth() != 0) send_request(CMD_EXIT, TGT_W'($urandom_range(255)), 1'b0, '0);
    send_request(CMD_EXIT, TGT_W'($urandom_range(255)), 1'b0, '0);
    wait_drained();

    while (requests_sent < TOTAL_REQUESTS) send_mixed(30);

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results never returned", 0, pending_results.size());

    $display("covered %0d requests, %0d results, deepest ready queue %0d",
             requests_sent, results_seen, deepest_queue);
    $display("status mix: ok %0d, tid invalid %0d, thread bad %0d, none %0d, last exit %0d",
             status_hits[ST_OK], status_hits[ST_TID_INVALID], status_hits[ST_THREAD_BAD],
             status_hits[ST_NO_THREAD], status_hits[ST_LAST_EXIT]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
